@@ rtl/slew_limited_bar_gauge_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the slew limited bar gauge
// Shared implication forms used by the gauge RTL checks.
// ----------------------------------------------------------------------------
`ifndef SLEW_LIMITED_BAR_GAUGE_TOP_DEFINES_SVH
`define SLEW_LIMITED_BAR_GAUGE_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define SLBG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define SLBG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/slbg_pkg.sv @@
// ----------------------------------------------------------------------------
// slbg_pkg
// Field widths, action codes and beat types of the slew limited bar gauge.
// ----------------------------------------------------------------------------
package slbg_pkg;

  // Field widths
  localparam int VALUE_BITS = 16;
  localparam int PIXEL_BITS = 12;
  localparam int PROD_BITS  = VALUE_BITS + PIXEL_BITS;
  localparam int CNT_BITS   = $clog2(PIXEL_BITS);

  // Configuration port
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 4;

  // Register indexes
  localparam logic [1:0] REG_BAR_WIDTH = 2'd0;
  localparam logic [1:0] REG_GAUGE_MAX = 2'd1;
  localparam logic [1:0] REG_GAUGE_MIN = 2'd2;
  localparam logic [1:0] REG_SLEW_STEP = 2'd3;

  // Register reset values
  localparam logic [PIXEL_BITS-1:0] BAR_WIDTH_RST = '0;
  localparam logic [VALUE_BITS-1:0] GAUGE_MAX_RST = VALUE_BITS'(100);
  localparam logic [VALUE_BITS-1:0] GAUGE_MIN_RST = '0;
  localparam logic [PIXEL_BITS-1:0] SLEW_STEP_RST = PIXEL_BITS'(1);

  // Action codes
  localparam logic [2:0] ACT_SET_NOW      = 3'd0;
  localparam logic [2:0] ACT_SET_ANIMATED = 3'd1;
  localparam logic [2:0] ACT_TICK         = 3'd2;
  localparam logic [2:0] ACT_RESCALE      = 3'd3;
  localparam logic [2:0] ACT_RESTART      = 3'd4;

  // Input beat
  typedef struct packed {
    logic [2:0]                   action;
    logic signed [VALUE_BITS-1:0] new_value;
  } slbg_in_t;

  // Result beat
  typedef struct packed {
    logic [PIXEL_BITS-1:0]        shown_width;
    logic [PIXEL_BITS-1:0]        target_width;
    logic signed [VALUE_BITS-1:0] gauge_value;
    logic                         settling;
    logic                         range_error;
  } slbg_out_t;

endpackage

@@ rtl/slew_limited_bar_gauge_top.sv @@
// ----------------------------------------------------------------------------
// slew_limited_bar_gauge_top
// Bar gauge width engine: clamps a gauge value, scales it to pixels with a
// shared shift-subtract divider, and slews the shown width toward target.
// ----------------------------------------------------------------------------
//   port group | direction | handshake              | payload
//   in_        | input     | in_valid / in_stall    | slbg_in_t   (action, new_value)
//   out_       | output    | out_valid / out_stall  | slbg_out_t  (widths, value, flags)
//   p*         | input     | psel/penable/pready    | four 32-bit registers at 4*i
//
// A set or rescale beat with a valid range and a value above the minimum
//   passes clamp, one multiply, one divider step per quotient bit, then the result.
// Tick, restart, unused actions, and set or rescale beats whose width is
//   zero (empty range or value at the minimum) go straight to the result; no divide runs.
// in_stall is high from acceptance until the result is written to the output
//   register; a held output beat only delays that final write.
// rst_n is synchronous, active low; configuration, gauge state, state and out_valid reset.
// ----------------------------------------------------------------------------
`include "slew_limited_bar_gauge_top_defines.svh"

module slew_limited_bar_gauge_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  slbg_pkg::slbg_in_t                   in_data,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output slbg_pkg::slbg_out_t                  out_data,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [slbg_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [slbg_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [slbg_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);
  import slbg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [PIXEL_BITS-1:0]        bar_width_r;
  logic signed [VALUE_BITS-1:0] gauge_max_r;
  logic signed [VALUE_BITS-1:0] gauge_min_r;
  logic [PIXEL_BITS-1:0]        slew_step_r;

  // Gauge state
  logic signed [VALUE_BITS-1:0] current_value_r;
  logic [PIXEL_BITS-1:0]        shown_px_r;
  logic [PIXEL_BITS-1:0]        target_px_r;

  // Working registers
  logic [2:0]                   action_r;
  logic signed [VALUE_BITS-1:0] new_value_r;
  logic [VALUE_BITS-1:0]        off_r;
  logic [VALUE_BITS-1:0]        span_r;
  logic [VALUE_BITS-1:0]        rem_r;
  logic [PIXEL_BITS-1:0]        num_lo_r;
  logic [PIXEL_BITS-1:0]        quo_r;
  logic [CNT_BITS-1:0]          cnt_r;

  logic                         out_valid_r;
  slbg_out_t                    out_data_r;

  // Combinational helpers
  logic                         cfg_wr;
  logic                         range_bad;
  logic signed [VALUE_BITS-1:0] val_src;
  logic signed [VALUE_BITS-1:0] val_hi;
  logic signed [VALUE_BITS-1:0] val_clamped;
  logic signed [VALUE_BITS:0]   span_wide;
  logic signed [VALUE_BITS:0]   off_wide;
  logic [PROD_BITS-1:0]         prod;
  logic [VALUE_BITS:0]          trial;
  logic                         trial_ge;
  logic [PIXEL_BITS-1:0]        gap;
  logic [PIXEL_BITS-1:0]        tick_px;
  logic                         out_free;

  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !(out_valid_r && out_stall);

  // Read back registers, zero extended
  always_comb begin
    unique case (paddr[3:2])
      REG_BAR_WIDTH: prdata = CFG_DATA_BITS'(bar_width_r);
      REG_GAUGE_MAX: prdata = CFG_DATA_BITS'($unsigned(gauge_max_r));
      REG_GAUGE_MIN: prdata = CFG_DATA_BITS'($unsigned(gauge_min_r));
      REG_SLEW_STEP: prdata = CFG_DATA_BITS'(slew_step_r);
      default:       prdata = '0;
    endcase
  end

  // Clamp to max first, then raise to min; form span and offset
  always_comb begin
    range_bad   = (gauge_max_r <= gauge_min_r);
    val_src     = ((action_r == ACT_SET_NOW) || (action_r == ACT_SET_ANIMATED)) ?
                  new_value_r : current_value_r;
    val_hi      = (val_src > gauge_max_r) ? gauge_max_r : val_src;
    val_clamped = (val_hi < gauge_min_r) ? gauge_min_r : val_hi;
    span_wide   = {gauge_max_r[VALUE_BITS-1], gauge_max_r}
                - {gauge_min_r[VALUE_BITS-1], gauge_min_r};
    off_wide    = {val_clamped[VALUE_BITS-1], val_clamped}
                - {gauge_min_r[VALUE_BITS-1], gauge_min_r};
  end

  // Shared multiplier and divider step
  always_comb begin
    prod     = PROD_BITS'(bar_width_r) * PROD_BITS'(off_r);
    trial    = {rem_r, num_lo_r[PIXEL_BITS-1]};
    trial_ge = (trial >= {1'b0, span_r});
  end

  // Slew the shown width toward target without overshoot
  always_comb begin
    if (shown_px_r < target_px_r) begin
      gap     = target_px_r - shown_px_r;
      tick_px = (slew_step_r >= gap) ? target_px_r : shown_px_r + slew_step_r;
    end else begin
      gap     = shown_px_r - target_px_r;
      tick_px = (slew_step_r >= gap) ? target_px_r : shown_px_r - slew_step_r;
    end
  end

  // Sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      bar_width_r     <= BAR_WIDTH_RST;
      gauge_max_r     <= GAUGE_MAX_RST;
      gauge_min_r     <= GAUGE_MIN_RST;
      slew_step_r     <= SLEW_STEP_RST;
      current_value_r <= '0;
      shown_px_r      <= '0;
      target_px_r     <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      // write configuration
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_BAR_WIDTH: bar_width_r <= pwdata[PIXEL_BITS-1:0];
          REG_GAUGE_MAX: gauge_max_r <= pwdata[VALUE_BITS-1:0];
          REG_GAUGE_MIN: gauge_min_r <= pwdata[VALUE_BITS-1:0];
          REG_SLEW_STEP: slew_step_r <= pwdata[PIXEL_BITS-1:0];
          default: ;
        endcase
      end

      // drop a taken result beat unless the finish step refills it
      if (out_valid_r && !out_stall && (state_r != S_FINISH)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            action_r    <= in_data.action;
            new_value_r <= in_data.new_value;
            state_r     <= S_CALC;
          end
        end

        S_CALC: begin
          quo_r <= '0;
          if ((action_r == ACT_SET_NOW) || (action_r == ACT_SET_ANIMATED) ||
              (action_r == ACT_RESCALE)) begin
            current_value_r <= val_clamped;
            off_r           <= off_wide[VALUE_BITS-1:0];
            span_r          <= span_wide[VALUE_BITS-1:0];
            if (range_bad || (val_clamped <= gauge_min_r)) begin
              state_r <= S_FINISH;
            end else begin
              state_r <= S_MUL;
            end
          end else begin
            if (action_r == ACT_RESTART) begin
              current_value_r <= gauge_min_r;
            end
            state_r <= S_FINISH;
          end
        end

        S_MUL: begin
          rem_r    <= prod[PROD_BITS-1:PIXEL_BITS];
          num_lo_r <= prod[PIXEL_BITS-1:0];
          cnt_r    <= CNT_BITS'(PIXEL_BITS - 1);
          state_r  <= S_DIV;
        end

        S_DIV: begin
          // one quotient bit per cycle
          rem_r    <= trial_ge ? VALUE_BITS'(trial - {1'b0, span_r}) :
                                 trial[VALUE_BITS-1:0];
          quo_r    <= {quo_r[PIXEL_BITS-2:0], trial_ge};
          num_lo_r <= {num_lo_r[PIXEL_BITS-2:0], 1'b0};
          cnt_r    <= cnt_r - CNT_BITS'(1);
          if (cnt_r == '0) begin
            state_r <= S_FINISH;
          end
        end

        S_FINISH: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r             <= 1'b1;
            out_data_r.gauge_value  <= current_value_r;
            out_data_r.range_error  <= range_bad;
            unique case (action_r)
              ACT_SET_NOW, ACT_RESCALE: begin
                shown_px_r              <= quo_r;
                target_px_r             <= quo_r;
                out_data_r.shown_width  <= quo_r;
                out_data_r.target_width <= quo_r;
                out_data_r.settling     <= 1'b0;
              end
              ACT_SET_ANIMATED: begin
                target_px_r             <= quo_r;
                out_data_r.shown_width  <= shown_px_r;
                out_data_r.target_width <= quo_r;
                out_data_r.settling     <= (shown_px_r != quo_r);
              end
              ACT_TICK: begin
                shown_px_r              <= tick_px;
                out_data_r.shown_width  <= shown_px_r;
                out_data_r.target_width <= target_px_r;
                out_data_r.settling     <= (tick_px != target_px_r);
              end
              ACT_RESTART: begin
                shown_px_r              <= '0;
                target_px_r             <= '0;
                out_data_r.shown_width  <= '0;
                out_data_r.target_width <= '0;
                out_data_r.settling     <= 1'b0;
              end
              default: begin
                out_data_r.shown_width  <= shown_px_r;
                out_data_r.target_width <= target_px_r;
                out_data_r.settling     <= (shown_px_r != target_px_r);
              end
            endcase
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Checks
  `SLBG_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall,
                    "accepted beat did not make the block busy")
  `SLBG_ASSERT_SAME(a_div_rem_below_span, clk, rst_n, state_r == S_DIV, rem_r < span_r,
                    "divider remainder not below span")
  `SLBG_ASSERT_NEXT(a_finish_emits, clk, rst_n, (state_r == S_FINISH) && out_free,
                    out_valid && !in_stall,
                    "finished beat did not reach the output register")

endmodule

@@ verif/tb_slew_limited_bar_gauge_top.sv @@
// ----------------------------------------------------------------------------
// tb_slew_limited_bar_gauge_top
// Self-checking bench for the slew limited bar gauge. A short directed plan
// (register writes and beats) walks clamping, empty ranges, slewing and the
// spare action codes. Random phases follow, each under a fresh register
// setting. Every result beat is checked field by field against a typed status
// or the in-bench gauge predictor; both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_slew_limited_bar_gauge_top;
  import slbg_pkg::*;

  // Spare action codes: the gauge only reports status on these
  localparam logic [2:0] ACT_RSVD_A = 3'd5;
  localparam logic [2:0] ACT_RSVD_B = 3'd6;
  localparam logic [2:0] ACT_RSVD_C = 3'd7;

  localparam logic signed [VALUE_BITS-1:0] VAL_TOP = 16'sh7fff;
  localparam logic signed [VALUE_BITS-1:0] VAL_BOT = 16'sh8000;
  localparam logic [PIXEL_BITS-1:0]        PIX_TOP = '1;

  localparam int PHASES      = 10;
  localparam int PHASE_BEATS = 140;
  localparam int MAX_REPORTS = 10;

  typedef enum logic {ROW_REG, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [1:0]               idx;
    logic [CFG_DATA_BITS-1:0] data;
    slbg_in_t                 beat;
    bit                       typed;
    slbg_out_t                want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  slbg_in_t in_data;
  logic out_valid;
  logic out_stall;
  slbg_out_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic pready;

  slew_limited_bar_gauge_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Register mirror and gauge state of the predictor
  logic [PIXEL_BITS-1:0]        cfg_bar;
  logic signed [VALUE_BITS-1:0] cfg_hi;
  logic signed [VALUE_BITS-1:0] cfg_lo;
  logic [PIXEL_BITS-1:0]        cfg_slew;
  logic signed [VALUE_BITS-1:0] held_value;
  logic [PIXEL_BITS-1:0]        disp_px;
  logic [PIXEL_BITS-1:0]        goal_px;

  slbg_out_t pending_status[$];
  plan_row_t plan[$];

  bit in_up;
  bit calm;
  int stall_left;
  int mismatches;
  int checked;
  int n_set, n_tick, n_redo, n_spare, n_settings;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin : watchdog
    #5_000_000;
    $display("timeout: %0d result beats still outstanding", pending_status.size());
    $display("FAIL");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Gauge predictor
  // -------------------------------------------------------------------------

  // Limit to the top first, then raise to the bottom
  function automatic logic signed [VALUE_BITS-1:0] clamp_to_range(
      logic signed [VALUE_BITS-1:0] v);
    logic signed [VALUE_BITS-1:0] r;
    r = v;
    if (r > cfg_hi) r = cfg_hi;
    if (r < cfg_lo) r = cfg_lo;
    return r;
  endfunction

  // bar * (v - lo) / (hi - lo), truncated; empty range gives zero
  function automatic logic [PIXEL_BITS-1:0] scale_to_px(logic signed [VALUE_BITS-1:0] v);
    longint hi, lo, x;
    hi = cfg_hi;
    lo = cfg_lo;
    x  = v;
    if (hi <= lo || x <= lo) return '0;
    if (x > hi) x = hi;
    return PIXEL_BITS'(longint'(cfg_bar) * (x - lo) / (hi - lo));
  endfunction

  // Apply one beat to the gauge state and return the status it reports
  function automatic slbg_out_t gauge_step(slbg_in_t b);
    slbg_out_t r;
    logic [PIXEL_BITS-1:0] gap;
    case (b.action)
      ACT_SET_NOW: begin
        held_value = clamp_to_range(b.new_value);
        goal_px    = scale_to_px(held_value);
        disp_px    = goal_px;
      end
      ACT_SET_ANIMATED: begin
        held_value = clamp_to_range(b.new_value);
        goal_px    = scale_to_px(held_value);
      end
      ACT_RESCALE: begin
        held_value = clamp_to_range(held_value);
        goal_px    = scale_to_px(held_value);
        disp_px    = goal_px;
      end
      ACT_RESTART: begin
        held_value = cfg_lo;
        disp_px    = '0;
        goal_px    = '0;
      end
      default: ;
    endcase
    r.shown_width = disp_px;
    // Step toward the target, never past it
    if (b.action == ACT_TICK && disp_px != goal_px) begin
      if (disp_px < goal_px) begin
        gap     = goal_px - disp_px;
        disp_px = (cfg_slew >= gap) ? goal_px : disp_px + cfg_slew;
      end else begin
        gap     = disp_px - goal_px;
        disp_px = (cfg_slew >= gap) ? goal_px : disp_px - cfg_slew;
      end
    end
    r.target_width = goal_px;
    r.gauge_value  = held_value;
    r.settling     = (disp_px != goal_px);
    r.range_error  = (cfg_hi <= cfg_lo);
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Plan rows and random picks
  // -------------------------------------------------------------------------

  function automatic slbg_out_t gauge_status(logic [PIXEL_BITS-1:0] s,
      logic [PIXEL_BITS-1:0] t, logic signed [VALUE_BITS-1:0] v, logic settle, logic err);
    slbg_out_t r;
    r.shown_width  = s;
    r.target_width = t;
    r.gauge_value  = v;
    r.settling     = settle;
    r.range_error  = err;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    plan_row_t r;
    r.kind  = ROW_REG;
    r.idx   = idx;
    r.data  = data;
    r.beat  = '0;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic plan_row_t beat_row(logic [2:0] act, logic signed [VALUE_BITS-1:0] v);
    plan_row_t r;
    r.kind           = ROW_BEAT;
    r.idx            = '0;
    r.data           = '0;
    r.beat.action    = act;
    r.beat.new_value = v;
    r.typed          = 1'b0;
    r.want           = '0;
    return r;
  endfunction

  function automatic plan_row_t typed_row(logic [2:0] act, logic signed [VALUE_BITS-1:0] v,
      slbg_out_t want);
    plan_row_t r;
    r       = beat_row(act, v);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  // Values inside the range (the most common pick), plus the edges and full-width noise
  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    longint lo, hi;
    lo = cfg_lo;
    hi = cfg_hi;
    case ($urandom_range(9))
      0: return VAL_TOP;
      1: return VAL_BOT;
      2: return cfg_lo;
      3: return cfg_hi;
      4, 5, 6, 7: begin
        if (hi > lo) return VALUE_BITS'(lo + longint'($urandom_range(32'(hi - lo))));
        return VALUE_BITS'($urandom);
      end
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_action();
    int r;
    r = $urandom_range(99);
    if (r < 15) return ACT_SET_NOW;
    if (r < 40) return ACT_SET_ANIMATED;
    if (r < 80) return ACT_TICK;
    if (r < 88) return ACT_RESCALE;
    if (r < 95) return ACT_RESTART;
    return 3'($urandom_range(ACT_RSVD_C, ACT_RSVD_A));
  endfunction

  // -------------------------------------------------------------------------
  // Channel and register drivers
  // -------------------------------------------------------------------------

  // Present one beat, hold it until accepted, then maybe idle for a burst
  task automatic send_beat(slbg_in_t b, bit typed, slbg_out_t want);
    slbg_out_t got;
    in_data <= b;
    if (!in_up) begin
      in_valid <= 1'b1;
      in_up = 1'b1;
    end
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = gauge_step(b);
    pending_status.push_back(typed ? want : got);
    case (b.action)
      ACT_SET_NOW, ACT_SET_ANIMATED: n_set++;
      ACT_TICK:                      n_tick++;
      ACT_RESCALE, ACT_RESTART:      n_redo++;
      default:                       n_spare++;
    endcase
    if (!calm && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      in_up = 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
  endtask

  // Drain the block, then write one register with a setup and an access phase
  task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    if (in_up) begin
      in_valid <= 1'b0;
      in_up = 1'b0;
    end
    while (pending_status.size() != 0) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_BAR_WIDTH: cfg_bar  = data[PIXEL_BITS-1:0];
      REG_GAUGE_MAX: cfg_hi   = data[VALUE_BITS-1:0];
      REG_GAUGE_MIN: cfg_lo   = data[VALUE_BITS-1:0];
      REG_SLEW_STEP: cfg_slew = data[PIXEL_BITS-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Result side: random stall bursts and the checker
  // -------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(15, 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    slbg_out_t want;
    bit bad;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result beat %p", $realtime, out_data);
      end else begin
        want = pending_status.pop_front();
        checked++;
        bad = (out_data.shown_width  !== want.shown_width)  ||
              (out_data.target_width !== want.target_width) ||
              (out_data.gauge_value  !== want.gauge_value)  ||
              (out_data.settling     !== want.settling)     ||
              (out_data.range_error  !== want.range_error);
        if (bad) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: beat %0d (exp/act) shown %0d/%0d target %0d/%0d",
                     $realtime, checked, want.shown_width, out_data.shown_width,
                     want.target_width, out_data.target_width);
            $display("    value %0d/%0d settle %b/%b err %b/%b",
                     want.gauge_value, out_data.gauge_value, want.settling,
                     out_data.settling, want.range_error, out_data.range_error);
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------

  initial begin : stimulus
    logic signed [VALUE_BITS-1:0] a, b, hi, lo;
    logic [PIXEL_BITS-1:0] bar, slew;
    slbg_in_t beat;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_up      = 1'b0;
    calm       = 1'b0;
    cfg_bar    = BAR_WIDTH_RST;
    cfg_hi     = GAUGE_MAX_RST;
    cfg_lo     = GAUGE_MIN_RST;
    cfg_slew   = SLEW_STEP_RST;
    held_value = '0;
    disp_px    = '0;
    goal_px    = '0;

    // Reset defaults: zero bar, then full bar and a one-pixel slew
    plan.push_back(typed_row(ACT_TICK, 16'sd0, gauge_status(0, 0, 0, 0, 0)));
    plan.push_back(typed_row(ACT_SET_NOW, 16'sd50, gauge_status(0, 0, 50, 0, 0)));
    plan.push_back(reg_row(REG_BAR_WIDTH, 32'(PIX_TOP)));
    plan.push_back(typed_row(ACT_SET_NOW, VAL_TOP, gauge_status(4095, 4095, 100, 0, 0)));
    plan.push_back(typed_row(ACT_SET_NOW, VAL_BOT, gauge_status(0, 0, 0, 0, 0)));
    plan.push_back(typed_row(ACT_SET_ANIMATED, 16'sd100, gauge_status(0, 4095, 100, 1, 0)));
    plan.push_back(typed_row(ACT_TICK, 16'sd0, gauge_status(0, 4095, 100, 1, 0)));
    plan.push_back(typed_row(ACT_TICK, 16'sd0, gauge_status(1, 4095, 100, 1, 0)));
    // Full slew lands on the target without overshoot
    plan.push_back(reg_row(REG_SLEW_STEP, 32'(PIX_TOP)));
    plan.push_back(typed_row(ACT_TICK, 16'sd0, gauge_status(2, 4095, 100, 0, 0)));
    plan.push_back(beat_row(ACT_SET_ANIMATED, 16'sd50));
    // Zero slew freezes the shown width; spare codes only report
    plan.push_back(reg_row(REG_SLEW_STEP, 32'd0));
    plan.push_back(beat_row(ACT_TICK, 16'sd0));
    plan.push_back(beat_row(ACT_RSVD_A, VAL_TOP));
    plan.push_back(beat_row(ACT_RSVD_B, VAL_BOT));
    plan.push_back(beat_row(ACT_RSVD_C, 16'sh5a5a));
    // Widest range
    plan.push_back(reg_row(REG_GAUGE_MAX, 32'(VAL_TOP)));
    plan.push_back(reg_row(REG_GAUGE_MIN, 32'(VAL_BOT)));
    plan.push_back(reg_row(REG_SLEW_STEP, 32'd1000));
    plan.push_back(beat_row(ACT_SET_NOW, 16'sd0));
    plan.push_back(beat_row(ACT_RESCALE, 16'sd0));
    // Empty range, then an inverted one where the bottom wins the clamp
    plan.push_back(reg_row(REG_GAUGE_MAX, 32'(VAL_BOT)));
    plan.push_back(typed_row(ACT_SET_NOW, 16'sd5, gauge_status(0, 0, VAL_BOT, 0, 1)));
    plan.push_back(reg_row(REG_GAUGE_MIN, 32'(VAL_TOP)));
    plan.push_back(typed_row(ACT_SET_ANIMATED, -16'sd100, gauge_status(0, 0, VAL_TOP, 0, 1)));
    plan.push_back(typed_row(ACT_RESCALE, 16'sd0, gauge_status(0, 0, VAL_TOP, 0, 1)));
    plan.push_back(typed_row(ACT_RESTART, 16'sd0, gauge_status(0, 0, VAL_TOP, 0, 1)));
    // Ordinary range; rescale after the top moves down
    plan.push_back(reg_row(REG_GAUGE_MAX, 32'sd1000));
    plan.push_back(reg_row(REG_GAUGE_MIN, -32'sd1000));
    plan.push_back(reg_row(REG_BAR_WIDTH, 32'd300));
    plan.push_back(beat_row(ACT_SET_NOW, 16'sd250));
    plan.push_back(beat_row(ACT_SET_ANIMATED, -16'sd1000));
    plan.push_back(beat_row(ACT_TICK, 16'sd0));
    plan.push_back(beat_row(ACT_RESTART, 16'sd0));
    plan.push_back(beat_row(ACT_SET_NOW, 16'sd900));
    plan.push_back(reg_row(REG_GAUGE_MAX, 32'sd500));
    plan.push_back(beat_row(ACT_RESCALE, 16'sd0));

    // Hold reset, then release it
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed plan
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        write_reg(plan[i].idx, plan[i].data);
        n_settings++;
      end else begin
        send_beat(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each under a new register setting
    for (int p = 0; p < PHASES; p++) begin
      calm = (p == PHASES - 1) || ($urandom_range(4) == 0);
      a = VALUE_BITS'($urandom);
      b = VALUE_BITS'($urandom);
      if (a == b) b = ~a;
      case ($urandom_range(9))
        0: begin hi = VAL_TOP; lo = VAL_BOT; end
        1: begin hi = a; lo = a; end
        2: begin hi = (a < b) ? a : b; lo = (a < b) ? b : a; end
        3: begin lo = (a == VAL_TOP) ? a - 16'sd1 : a; hi = lo + 16'sd1; end
        default: begin hi = (a > b) ? a : b; lo = (a > b) ? b : a; end
      endcase
      case ($urandom_range(3))
        0: bar = '0;
        1: bar = PIX_TOP;
        default: bar = PIXEL_BITS'($urandom);
      endcase
      case ($urandom_range(5))
        0: slew = '0;
        1: slew = PIXEL_BITS'(1);
        2: slew = PIX_TOP;
        3, 4: slew = PIXEL_BITS'($urandom_range(64, 1));
        default: slew = PIXEL_BITS'($urandom);
      endcase
      write_reg(REG_BAR_WIDTH, 32'(bar));
      write_reg(REG_GAUGE_MAX, 32'(hi));
      write_reg(REG_GAUGE_MIN, 32'(lo));
      write_reg(REG_SLEW_STEP, 32'(slew));
      n_settings++;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        beat.action    = pick_action();
        beat.new_value = pick_value();
        send_beat(beat, 1'b0, '0);
      end
    end

    // Drop valid, drain, and keep watching for stray beats
    if (in_up) begin
      in_valid <= 1'b0;
      in_up = 1'b0;
    end
    while (pending_status.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Checked %0d result beats: %0d set, %0d tick, %0d rescale/restart, %0d spare",
             checked, n_set, n_tick, n_redo, n_spare);
    $display("Register settings exercised: %0d; mismatches: %0d", n_settings, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
